>>> hw/rtl/mdr_pkg.sv
package mdr_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int KEY_W = 19;

    localparam logic [7:0] MT_ACK   = 8'h22;
    localparam logic [7:0] MT_REPLY = 8'h12;

    localparam logic [2:0] MODEL_CORE200  = 3'd1;
    localparam logic [2:0] MODEL_CORE300  = 3'd2;
    localparam logic [2:0] MODEL_CORE400  = 3'd3;
    localparam logic [2:0] MODEL_VITAL100 = 3'd4;
    localparam logic [2:0] MODEL_VITAL200 = 3'd5;

    localparam logic [2:0] DEC_NONE         = 3'd0;
    localparam logic [2:0] DEC_CORE_STATUS  = 3'd1;
    localparam logic [2:0] DEC_CORE_TIMER   = 3'd2;
    localparam logic [2:0] DEC_VITAL_STATUS = 3'd3;
    localparam logic [2:0] DEC_VITAL_TIMER  = 3'd4;

    // payload-type bytes that select a decoder
    localparam logic [7:0] PT_STATUS_LO      = 8'h40;
    localparam logic [7:0] PT_STATUS_HI_A    = 8'h30;
    localparam logic [7:0] PT_STATUS_HI_B    = 8'hB0;
    localparam logic [7:0] PT_STATUS_HI_C200 = 8'h60;
    localparam logic [7:0] PT_TIMER_LO       = 8'hA2;
    localparam logic [7:0] PT_TIMER_HI_REPLY = 8'h65;
    localparam logic [7:0] PT_TIMER_HI_SET   = 8'h66;
    localparam logic [7:0] PT_TIMER_HI_C200  = 8'h64;
    localparam logic [7:0] PT_VSTATUS_HI     = 8'h00;
    localparam logic [7:0] PT_VSTATUS_LO     = 8'h55;
    localparam logic [7:0] PT_VTIMER_HI_REPLY = 8'h1A;
    localparam logic [7:0] PT_VTIMER_HI_SET  = 8'h1B;
    localparam logic [7:0] PT_VTIMER_LO      = 8'h50;

    typedef struct packed {
        logic [2:0] model_code;
        logic [7:0] message_type;
        logic [7:0] type_high;
        logic [7:0] type_low;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_payload;
    } msg_beat_t;

    typedef struct packed {
        logic       payload_changed;
        logic       ack_request;
        logic [2:0] decoder_select;
        logic [7:0] payload_hash;
    } res_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] h, input logic [7:0] b);
        logic [7:0] x;
        x = h ^ b;
        return {x[6:0], x[7]};
    endfunction

    function automatic logic [2:0] pick_decoder(input logic [2:0] model,
                                                input logic [7:0] mt,
                                                input logic [7:0] th,
                                                input logic [7:0] tl);
        logic       a22;
        logic       a12;
        logic [2:0] sel;
        a22 = (mt == MT_ACK);
        a12 = (mt == MT_REPLY);
        sel = DEC_NONE;
        if (model == MODEL_CORE300 || model == MODEL_CORE400)
        begin
            if (a22 && tl == PT_STATUS_LO && (th == PT_STATUS_HI_A || th == PT_STATUS_HI_B))
                sel = DEC_CORE_STATUS;
            else if (a12 && th == PT_TIMER_HI_REPLY && tl == PT_TIMER_LO)
                sel = DEC_CORE_TIMER;
            else if (a22 && th == PT_TIMER_HI_SET && tl == PT_TIMER_LO)
                sel = DEC_CORE_TIMER;
        end
        else if (model == MODEL_CORE200)
        begin
            if (a22 && th == PT_STATUS_HI_C200 && tl == PT_STATUS_LO)
                sel = DEC_CORE_STATUS;
            else if (a22 && th == PT_TIMER_HI_C200 && tl == PT_TIMER_LO)
                sel = DEC_CORE_TIMER;
            else if (a12 && th == PT_TIMER_HI_REPLY && tl == PT_TIMER_LO)
                sel = DEC_CORE_TIMER;
            else if (a22 && th == PT_TIMER_HI_SET && tl == PT_TIMER_LO)
                sel = DEC_CORE_TIMER;
        end
        else if (model == MODEL_VITAL100 || model == MODEL_VITAL200)
        begin
            if (a22 && th == PT_VSTATUS_HI && tl == PT_VSTATUS_LO)
                sel = DEC_VITAL_STATUS;
            else if (a12 && th == PT_VTIMER_HI_REPLY && tl == PT_VTIMER_LO)
                sel = DEC_VITAL_TIMER;
            else if (a22 && th == PT_VTIMER_HI_SET && tl == PT_VTIMER_LO)
                sel = DEC_VITAL_TIMER;
        end
        return sel;
    endfunction

endpackage

>>> hw/rtl/mdr_in_if.sv
interface mdr_in_if;
    import mdr_pkg::*;

    logic      valid;
    logic      ready;
    msg_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/mdr_out_if.sv
interface mdr_out_if;
    import mdr_pkg::*;

    logic      valid;
    logic      ready;
    res_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/message_dedup_and_route.sv
// non-last payload byte: folded into the running hash, no result, block stays idle
// last byte: cache entries 0..CACHE_ENTRIES-1 visited in order by the single key
//   comparator (scan stops at the first hit), result registered once output is free
// empty payload: result valid in the cycle after acceptance
// reset: all cache entries invalid, running hash zero, no result pending
module message_dedup_and_route (
    input  logic      clk,
    input  logic      rst_n,
    mdr_in_if.sink    msg,
    mdr_out_if.source result
);
    import mdr_pkg::*;

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CACHE_ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]       hash_reg, hash_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             ack_reg, ack_next;
    logic [2:0]       dec_reg, dec_next;
    logic             changed_reg, changed_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             out_valid_reg, out_valid_next;
    res_beat_t        out_data_reg, out_data_next;

    logic             entry_valid_reg [CACHE_ENTRIES];
    logic [KEY_W-1:0] entry_key_reg   [CACHE_ENTRIES];
    logic [7:0]       entry_hash_reg  [CACHE_ENTRIES];

    logic             wr_en;
    logic             wr_fill;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] scan_idx;
    logic             key_hit;
    logic             accept;
    logic             out_free;

    assign scan_idx = idx_reg[IDX_W-1:0];
    assign key_hit  = entry_valid_reg[scan_idx] && (entry_key_reg[scan_idx] == key_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign msg.ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = msg.valid && msg.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        hash_next       = hash_reg;
        key_next        = key_reg;
        ack_next        = ack_reg;
        dec_next        = dec_reg;
        changed_next    = changed_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_fill         = 1'b0;
        wr_idx          = scan_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ack_next = (msg.payload.message_type == MT_ACK);
                    dec_next = pick_decoder(msg.payload.model_code, msg.payload.message_type,
                                            msg.payload.type_high, msg.payload.type_low);
                    key_next = {msg.payload.model_code, msg.payload.type_high,
                                msg.payload.type_low};
                    if (msg.payload.empty_payload)
                    begin
                        hash_next      = 8'h00;
                        out_valid_next = 1'b1;
                        out_data_next.payload_changed = 1'b1;
                        out_data_next.ack_request     = ack_next;
                        out_data_next.decoder_select  = dec_next;
                        out_data_next.payload_hash    = 8'h00;
                    end
                    else
                    begin
                        hash_next = fold_byte(msg.payload.first_byte ? 8'h00 : hash_reg,
                                              msg.payload.data_byte);
                        if (msg.payload.last_byte)
                        begin
                            idx_next        = '0;
                            free_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_hit)
                begin
                    changed_next = (entry_hash_reg[scan_idx] != hash_reg);
                    wr_en        = changed_next;
                    state_next   = ST_DONE;
                end
                else
                begin
                    if (!entry_valid_reg[scan_idx] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_idx;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        // no hit: fill the lowest free entry, if any
                        changed_next = 1'b1;
                        wr_en        = free_found_next;
                        wr_fill      = free_found_next;
                        wr_idx       = free_idx_next;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.payload_changed = changed_reg;
                    out_data_next.ack_request     = ack_reg;
                    out_data_next.decoder_select  = changed_reg ? dec_reg : DEC_NONE;
                    out_data_next.payload_hash    = hash_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            hash_reg       <= hash_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            if (wr_fill)
            begin
                entry_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        ack_reg      <= ack_next;
        dec_reg      <= dec_next;
        changed_reg  <= changed_next;
        free_idx_reg <= free_idx_next;
        out_data_reg <= out_data_next;
        if (wr_en)
        begin
            entry_hash_reg[wr_idx] <= hash_reg;
        end
        if (wr_fill)
        begin
            entry_key_reg[wr_idx] <= key_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg <= LAST_IDX)
        else $error("scan index past last entry");

    a_unchanged_no_decoder: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.payload_changed
            |-> result.payload.decoder_select == DEC_NONE)
        else $error("decoder selected for unchanged message");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && msg.payload.empty_payload
            |=> result.valid && result.payload.payload_changed
                && result.payload.payload_hash == 8'h00)
        else $error("empty payload result missing or wrong");
`endif

endmodule
